FILE: src/assert_macros.svh
// Assertion macros shared by the queue RTL.
// Needs no other file; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define TSMQ_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// A condition in one cycle that must be followed by another in the next.
`define TSMQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    `TSMQ_ASSERT(label, clk, rstn, (ante) |=> (cons), msg)

`endif

FILE: src/tsmq_pkg.sv
// Package for the two-stack minimum queue: sizes, command and status codes,
// and the sequencer state type. Depends on nothing.
package tsmq_pkg;

    localparam int DEPTH   = 1024;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int ENTRY_W = 2 * DATA_W;
    localparam int COUNT_W = 11;

    typedef enum logic [1:0] {
        CMD_ENQ = 2'd0,
        CMD_DEQ = 2'd1,
        CMD_CLR = 2'd2,
        CMD_INS = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_XFER_RD,
        S_XFER_WR,
        S_POP,
        S_TOP_RD,
        S_TOP_LD,
        S_RESP
    } state_t;

endpackage

FILE: src/two_stack_min_queue.sv
// Channel  | ports                         | contents
// request  | s_tvalid s_tready s_tdata/user| tuser: cmd; tdata: data_in
// result   | m_tvalid m_tready m_tdata/user| tuser: status; tdata: value, min, count
//
// After S_DECODE, enqueue, clear and errors go to S_RESP; inspect and a dequeue that empties
// the output stack pass S_POP first, and a dequeue that leaves a new top passes S_POP, S_TOP_RD
// and S_TOP_LD to read it back from the output stack memory. The sequencer returns to S_IDLE
// after each result. An empty output stack is first refilled from the input stack (per element:
// one memory read, one compare and write through the min unit). Reset (synchronous, aresetn low)
// empties both stacks; memories are not cleared. A result waits while m_tready is low.
// Depends on tsmq_pkg, tsmq_stack_ram, tsmq_min_unit and assert_macros.svh.
`include "assert_macros.svh"

module two_stack_min_queue (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] data_in
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [31:0] value_out, [63:32] min_out,
                                   // [74:64] count, [79:75] zero
    output logic [1:0]  m_tuser    // [1:0] status
);
    import tsmq_pkg::*;

    state_t                  state_reg, state_next;
    cmd_t                    cmd_reg, cmd_next;
    logic [DATA_W-1:0]       data_reg, data_next;
    status_t                 status_reg, status_next;
    logic [DATA_W-1:0]       value_reg, value_next;
    logic [CNT_W-1:0]        in_cnt_reg, in_cnt_next;
    logic [CNT_W-1:0]        out_cnt_reg, out_cnt_next;
    logic [DATA_W-1:0]       in_top_min_reg, in_top_min_next;
    logic [DATA_W-1:0]       out_top_val_reg, out_top_val_next;
    logic [DATA_W-1:0]       out_top_min_reg, out_top_min_next;
    logic                    m_valid_reg, m_valid_next;
    status_t                 m_status_reg, m_status_next;
    logic [DATA_W-1:0]       m_value_reg, m_value_next;
    logic [DATA_W-1:0]       m_min_reg, m_min_next;
    logic [COUNT_W-1:0]      m_count_reg, m_count_next;

    logic                    accept;
    logic                    slot_free;
    logic [CNT_W:0]          total_cnt;
    logic [CNT_W-1:0]        in_dec;
    logic [CNT_W-1:0]        out_dec;
    logic                    in_wr;
    logic [ADDR_W-1:0]       in_raddr;
    logic [ENTRY_W-1:0]      in_rdata;
    logic                    out_wr;
    logic [ADDR_W-1:0]       out_raddr;
    logic [ENTRY_W-1:0]      out_rdata;
    logic [DATA_W-1:0]       unit_a, unit_b, unit_y;
    logic [DATA_W-1:0]       enq_min;
    logic [DATA_W-1:0]       xfer_min;
    logic [DATA_W-1:0]       queue_min;

    assign accept    = s_tvalid && s_tready;
    assign slot_free = !m_valid_reg || m_tready;
    assign total_cnt = {1'b0, in_cnt_reg} + {1'b0, out_cnt_reg};
    assign in_dec    = in_cnt_reg - CNT_W'(1);
    assign out_dec   = out_cnt_reg - CNT_W'(1);

    // Stack memories: each entry holds {running minimum, value}.
    tsmq_stack_ram #(.WIDTH(ENTRY_W), .DEPTH_P(DEPTH)) u_in_ram (
        .aclk  (aclk),
        .we    (in_wr),
        .waddr (in_cnt_reg[ADDR_W-1:0]),
        .wdata ({enq_min, data_reg}),
        .raddr (in_raddr),
        .rdata (in_rdata)
    );

    tsmq_stack_ram #(.WIDTH(ENTRY_W), .DEPTH_P(DEPTH)) u_out_ram (
        .aclk  (aclk),
        .we    (out_wr),
        .waddr (out_cnt_reg[ADDR_W-1:0]),
        .wdata ({xfer_min, in_rdata[DATA_W-1:0]}),
        .raddr (out_raddr),
        .rdata (out_rdata)
    );

    // The one compare unit, shared by push, transfer and the result minimum.
    tsmq_min_unit u_min (
        .op_a  (unit_a),
        .op_b  (unit_b),
        .min_y (unit_y)
    );

    assign enq_min  = (in_cnt_reg == '0) ? data_reg : unit_y;
    assign xfer_min = (out_cnt_reg == '0) ? in_rdata[DATA_W-1:0] : unit_y;

    // Minimum of the whole queue, from the two stack tops.
    always_comb begin
        if (in_cnt_reg == '0 && out_cnt_reg == '0) begin
            queue_min = '0;
        end else if (in_cnt_reg == '0) begin
            queue_min = out_top_min_reg;
        end else if (out_cnt_reg == '0) begin
            queue_min = in_top_min_reg;
        end else begin
            queue_min = unit_y;
        end
    end

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if ((cmd_reg == CMD_DEQ || cmd_reg == CMD_INS) && total_cnt != '0) begin
                    state_next = (out_cnt_reg == '0) ? S_XFER_RD : S_POP;
                end else begin
                    state_next = S_RESP;
                end
            end
            S_XFER_RD: state_next = S_XFER_WR;
            S_XFER_WR: state_next = (in_cnt_reg == '0) ? S_POP : S_XFER_RD;
            S_POP: begin
                if (cmd_reg == CMD_DEQ && out_cnt_reg > CNT_W'(1)) begin
                    state_next = S_TOP_RD;
                end else begin
                    state_next = S_RESP;
                end
            end
            S_TOP_RD: state_next = S_TOP_LD;
            S_TOP_LD: state_next = S_RESP;
            S_RESP: begin
                if (slot_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, memory controls and unit operands.
    always_comb begin
        s_tready  = 1'b0;
        in_wr     = 1'b0;
        out_wr    = 1'b0;
        in_raddr  = in_dec[ADDR_W-1:0];
        out_raddr = out_dec[ADDR_W-1:0];
        unit_a    = in_top_min_reg;
        unit_b    = out_top_min_reg;
        unique case (state_reg)
            S_IDLE: s_tready = 1'b1;
            S_DECODE: begin
                unit_a = data_reg;
                unit_b = in_top_min_reg;
                in_wr  = (cmd_reg == CMD_ENQ) && (total_cnt < (CNT_W + 1)'(DEPTH));
            end
            S_XFER_WR: begin
                unit_a = in_rdata[DATA_W-1:0];
                unit_b = out_top_min_reg;
                out_wr = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Datapath and counter updates.
    always_comb begin
        cmd_next         = cmd_reg;
        data_next        = data_reg;
        status_next      = status_reg;
        value_next       = value_reg;
        in_cnt_next      = in_cnt_reg;
        out_cnt_next     = out_cnt_reg;
        in_top_min_next  = in_top_min_reg;
        out_top_val_next = out_top_val_reg;
        out_top_min_next = out_top_min_reg;
        m_status_next    = m_status_reg;
        m_value_next     = m_value_reg;
        m_min_next       = m_min_reg;
        m_count_next     = m_count_reg;
        m_valid_next     = m_tready ? 1'b0 : m_valid_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd_next    = cmd_t'(s_tuser[1:0]);
                    data_next   = s_tdata[DATA_W-1:0];
                    status_next = STAT_OK;
                    value_next  = '0;
                end
            end
            S_DECODE: begin
                unique case (cmd_reg)
                    CMD_ENQ: begin
                        if (in_wr) begin
                            in_top_min_next = enq_min;
                            in_cnt_next     = in_cnt_reg + CNT_W'(1);
                        end else begin
                            status_next = STAT_FULL;
                        end
                    end
                    CMD_CLR: begin
                        in_cnt_next  = '0;
                        out_cnt_next = '0;
                    end
                    default: begin
                        if (total_cnt == '0) begin
                            status_next = STAT_EMPTY;
                        end
                    end
                endcase
            end
            S_XFER_RD: begin
                in_cnt_next = in_dec;
            end
            S_XFER_WR: begin
                out_top_val_next = in_rdata[DATA_W-1:0];
                out_top_min_next = xfer_min;
                out_cnt_next     = out_cnt_reg + CNT_W'(1);
            end
            S_POP: begin
                value_next = out_top_val_reg;
                if (cmd_reg == CMD_DEQ) begin
                    out_cnt_next = out_dec;
                end
            end
            S_TOP_LD: begin
                out_top_val_next = out_rdata[DATA_W-1:0];
                out_top_min_next = out_rdata[ENTRY_W-1:DATA_W];
            end
            S_RESP: begin
                if (slot_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_value_next  = value_reg;
                    m_min_next    = queue_min;
                    m_count_next  = COUNT_W'(total_cnt);
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            in_cnt_reg  <= '0;
            out_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            in_cnt_reg  <= in_cnt_next;
            out_cnt_reg <= out_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        cmd_reg         <= cmd_next;
        data_reg        <= data_next;
        status_reg      <= status_next;
        value_reg       <= value_next;
        in_top_min_reg  <= in_top_min_next;
        out_top_val_reg <= out_top_val_next;
        out_top_min_reg <= out_top_min_next;
        m_status_reg    <= m_status_next;
        m_value_reg     <= m_value_next;
        m_min_reg       <= m_min_next;
        m_count_reg     <= m_count_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {5'b0, m_count_reg, m_min_reg, m_value_reg};

    // The two stacks together never hold more than the queue depth.
    `TSMQ_ASSERT(a_total_bound, aclk, aresetn,
        total_cnt <= (CNT_W + 1)'(DEPTH), "queue count exceeds depth")

    // A pop is only reached with a filled output stack.
    `TSMQ_ASSERT(a_pop_nonempty, aclk, aresetn,
        state_reg != S_POP || out_cnt_reg != '0, "pop from empty output stack")

    // Once the input stack is drained the transfer ends in a pop.
    `TSMQ_ASSERT_NEXT(a_xfer_end, aclk, aresetn,
        state_reg == S_XFER_WR && in_cnt_reg == '0, state_reg == S_POP,
        "transfer did not end in a pop")

endmodule

FILE: src/tsmq_stack_ram.sv
// Single-port-write, single-port-read stack memory with a registered read.
// Generic; used by the queue top level for both stacks.
module tsmq_stack_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH_P = 1024
) (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [$clog2(DEPTH_P)-1:0] waddr,
    input  logic [WIDTH-1:0]           wdata,
    input  logic [$clog2(DEPTH_P)-1:0] raddr,
    output logic [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem [DEPTH_P];

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

FILE: src/tsmq_min_unit.sv
// Shared signed minimum unit of the queue sequencer.
// Uses tsmq_pkg for the data width.
module tsmq_min_unit (
    input  logic signed [tsmq_pkg::DATA_W-1:0] op_a,
    input  logic signed [tsmq_pkg::DATA_W-1:0] op_b,
    output logic signed [tsmq_pkg::DATA_W-1:0] min_y
);
    import tsmq_pkg::*;

    // One signed compare and a select.
    assign min_y = (op_a < op_b) ? op_a : op_b;

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the two-stack minimum queue: a scoreboard class predicts
// every reply from its own pair of stacks, and tasks drive directed and random requests.
// Depends on tsmq_pkg and the two_stack_min_queue RTL.
`timescale 1ns / 100ps

module tb;
    import tsmq_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int IN_SIDE      = 0;
    localparam int OUT_SIDE     = 1;

    // One reply of the queue, as the block returns it.
    typedef struct packed {
        status_t              status;
        logic [DATA_W-1:0]    value;
        logic [DATA_W-1:0]    least;
        logic [COUNT_W-1:0]   count;
    } queue_reply_t;

    // Predicts the reply to each accepted request and checks the replies in order.
    class min_queue_scoreboard;
        logic signed [DATA_W-1:0] vals [2][DEPTH];
        logic signed [DATA_W-1:0] mins [2][DEPTH];
        int                       depth_of [2];
        queue_reply_t             awaited [$];
        int                       fails;

        function new();
            depth_of[IN_SIDE]  = 0;
            depth_of[OUT_SIDE] = 0;
            fails              = 0;
        endfunction

        function logic signed [DATA_W-1:0] lesser(logic signed [DATA_W-1:0] a,
                                                  logic signed [DATA_W-1:0] b);
            return (a < b) ? a : b;
        endfunction

        function int held();
            return depth_of[IN_SIDE] + depth_of[OUT_SIDE];
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // Each stack entry carries the minimum of itself and everything below it.
        function void push(int side, logic signed [DATA_W-1:0] v);
            int n;
            n = depth_of[side];
            vals[side][n] = v;
            mins[side][n] = (n == 0) ? v : lesser(v, mins[side][n-1]);
            depth_of[side] = n + 1;
        endfunction

        function void note_request(cmd_t c, logic [DATA_W-1:0] d);
            queue_reply_t r;
            int           ni;
            int           no;
            r        = '0;
            r.status = STAT_OK;
            case (c)
                CMD_ENQ: begin
                    if (held() >= DEPTH) r.status = STAT_FULL;
                    else push(IN_SIDE, d);
                end
                CMD_CLR: begin
                    depth_of[IN_SIDE]  = 0;
                    depth_of[OUT_SIDE] = 0;
                end
                default: begin
                    if (held() == 0) begin
                        r.status = STAT_EMPTY;
                    end else begin
                        // An empty output stack is refilled from the input stack, reversed.
                        if (depth_of[OUT_SIDE] == 0) begin
                            while (depth_of[IN_SIDE] > 0) begin
                                depth_of[IN_SIDE]--;
                                push(OUT_SIDE, vals[IN_SIDE][depth_of[IN_SIDE]]);
                            end
                        end
                        r.value = vals[OUT_SIDE][depth_of[OUT_SIDE]-1];
                        if (c == CMD_DEQ) depth_of[OUT_SIDE]--;
                    end
                end
            endcase
            // The queue minimum is the lesser of the two stack-top minima.
            ni = depth_of[IN_SIDE];
            no = depth_of[OUT_SIDE];
            if (ni > 0 && no > 0) r.least = lesser(mins[IN_SIDE][ni-1], mins[OUT_SIDE][no-1]);
            else if (ni > 0) r.least = mins[IN_SIDE][ni-1];
            else if (no > 0) r.least = mins[OUT_SIDE][no-1];
            r.count = COUNT_W'(held());
            awaited.push_back(r);
        endfunction

        function int field_differs(string name, logic [DATA_W-1:0] want,
                                   logic [DATA_W-1:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
                return 1;
            end
            return 0;
        endfunction

        function void check_result(logic [1:0] st, logic [DATA_W-1:0] v,
                                   logic [DATA_W-1:0] mn, logic [COUNT_W-1:0] n);
            queue_reply_t want;
            if (awaited.size() == 0) begin
                $display("%0t: reply with no request outstanding, expected none, got %0d %h %h %0d",
                         $time, st, v, mn, n);
                fails++;
                return;
            end
            want = awaited.pop_front();
            fails += field_differs("status", DATA_W'(want.status), DATA_W'(st));
            fails += field_differs("value", want.value, v);
            fails += field_differs("min", want.least, mn);
            fails += field_differs("count", DATA_W'(want.count), DATA_W'(n));
        endfunction
    endclass

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [31:0]        s_tdata  = '0;   // [31:0] data_in
    logic [1:0]         s_tuser  = CMD_ENQ;   // [1:0] cmd
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [79:0]        m_tdata;   // [31:0] value_out, [63:32] min_out, [74:64] count
    logic [1:0]         m_tuser;   // [1:0] status

    int                  send_idle_pct = 12;
    int                  recv_idle_pct = 60;
    int                  cycles        = 0;
    min_queue_scoreboard board;

    two_stack_min_queue dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #6 aclk = ~aclk;

    // The receiver stalls at random, as the current phase asks.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Every reply taken is checked against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.check_result(m_tuser, m_tdata[31:0], m_tdata[63:32], m_tdata[74:64]);
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Values lean towards the extremes, so the running minima change often.
    function automatic logic [DATA_W-1:0] random_value();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return $urandom_range(40) - 20;
            default: return $urandom;
        endcase
    endfunction

    // Offers one request, with random idle cycles first, and waits until it is taken.
    task automatic send_request(cmd_t c, logic [DATA_W-1:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_request(c, d);
    endtask

    // Random traffic: mostly single commands, with runs of enqueues and of dequeues and inspects.
    task automatic run_random(int n_items);
        int done;
        int pick;
        int len;
        done = 0;
        while (done < n_items) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                len = $urandom_range(30, 1);
                repeat (len) send_request(CMD_ENQ, random_value());
                done += len;
            end else if (pick < 14) begin
                len = $urandom_range(30, 1);
                repeat (len) send_request(($urandom_range(3) == 0) ? CMD_INS : CMD_DEQ, $urandom);
                done += len;
            end else begin
                pick = $urandom_range(99);
                if (pick < 45)      send_request(CMD_ENQ, random_value());
                else if (pick < 75) send_request(CMD_DEQ, $urandom);
                else if (pick < 92) send_request(CMD_INS, $urandom);
                else                send_request(CMD_CLR, $urandom);
                done++;
            end
        end
    endtask

    // Fills the queue to its bound and works on it with both stacks loaded.
    task automatic fill_to_full();
        while (board.held() < DEPTH) send_request(CMD_ENQ, random_value());
        repeat (4) send_request(CMD_ENQ, random_value());
        send_request(CMD_INS, $urandom);
        send_request(CMD_ENQ, random_value());
        repeat (3) send_request(CMD_DEQ, $urandom);
        repeat (4) send_request(CMD_ENQ, random_value());
        repeat (20) send_request(($urandom_range(3) == 0) ? CMD_INS : CMD_DEQ, $urandom);
        send_request(CMD_CLR, $urandom);
    endtask

    initial begin
        board = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: errors on an empty queue, extreme values, a transfer with
        // both stacks in use, and clears.
        send_request(CMD_DEQ, 32'h0000_0000);
        send_request(CMD_INS, 32'hFFFF_FFFF);
        send_request(CMD_CLR, 32'h0000_0000);
        send_request(CMD_ENQ, 32'h7FFF_FFFF);
        send_request(CMD_ENQ, 32'h8000_0000);
        send_request(CMD_ENQ, 32'h0000_0000);
        send_request(CMD_ENQ, 32'hFFFF_FFFF);
        send_request(CMD_ENQ, 32'h0000_0001);
        send_request(CMD_INS, 32'h0000_0000);
        send_request(CMD_ENQ, 32'h0000_0005);
        send_request(CMD_DEQ, 32'h0000_0000);
        send_request(CMD_DEQ, 32'h0000_0000);
        send_request(CMD_INS, 32'h0000_0000);
        send_request(CMD_DEQ, 32'h0000_0000);
        send_request(CMD_DEQ, 32'h0000_0000);
        send_request(CMD_DEQ, 32'h0000_0000);
        send_request(CMD_DEQ, 32'h0000_0000);
        send_request(CMD_DEQ, 32'h0000_0000);
        send_request(CMD_ENQ, 32'hAAAA_AAAA);
        send_request(CMD_ENQ, 32'h5555_5555);
        send_request(CMD_CLR, 32'h0000_0000);
        send_request(CMD_INS, 32'h0000_0000);
        send_request(CMD_ENQ, 32'hFFFF_FFFE);
        send_request(CMD_DEQ, 32'h0000_0000);

        // Random part in three idling phases; the last also fills the queue.
        run_random(40);
        send_idle_pct = 60;
        recv_idle_pct = 12;
        run_random(40);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(40);
        fill_to_full();
        s_tvalid <= 1'b0;

        // Drain, then wait for any stray reply.
        while (board.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.fails == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+src
src/tsmq_pkg.sv
src/tsmq_stack_ram.sv
src/tsmq_min_unit.sv
src/two_stack_min_queue.sv
tb/tb.sv
